@@ hdl/mps_pkg.sv @@
// ----------------------------------------------------------------------------
// mps_pkg: shared types, constants and microprogram
// Payload structs, register codes, control word layout and the sequencer
// program table for the moisture percent statistics block.
// ----------------------------------------------------------------------------
package mps_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int PCT_BITS    = 15;
    localparam int FS_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Derived widths
    localparam int PROD_BITS = SAMPLE_BITS + PCT_BITS;
    localparam int DIV_BITS  = (FS_BITS > COUNT_BITS) ? FS_BITS : COUNT_BITS;
    localparam int CMP_BITS  = (FS_BITS > SAMPLE_BITS) ? FS_BITS : SAMPLE_BITS;
    localparam int STEP_BITS = $clog2(PCT_BITS);
    localparam int PC_BITS   = 4;

    // 100.00 percent in Q7.8
    localparam logic [PCT_BITS-1:0] PCT_FULL = 15'd25600;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT  = 2'd2;

    // Program addresses
    localparam logic [PC_BITS-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_BITS-1:0] PC_MUL   = 4'd1;
    localparam logic [PC_BITS-1:0] PC_LDPCT = 4'd2;
    localparam logic [PC_BITS-1:0] PC_DPCT  = 4'd3;
    localparam logic [PC_BITS-1:0] PC_PCT   = 4'd4;
    localparam logic [PC_BITS-1:0] PC_STATS = 4'd5;
    localparam logic [PC_BITS-1:0] PC_DMEAN = 4'd6;
    localparam logic [PC_BITS-1:0] PC_MEAN  = 4'd7;
    localparam logic [PC_BITS-1:0] PC_OUT   = 4'd8;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   stats_enable;
        logic [COUNT_BITS-1:0]  sample_count;
    } t_in_item;

    typedef struct packed {
        logic [PCT_BITS-1:0] percent;
        logic                out_of_range;
        logic [PCT_BITS-1:0] minimum;
        logic [PCT_BITS-1:0] maximum;
        logic [PCT_BITS-1:0] average;
    } t_out_item;

    typedef struct packed {
        logic [FS_BITS-1:0]  full_scale;
        logic [PCT_BITS-1:0] high_limit;
        logic [PCT_BITS-1:0] low_limit;
    } t_cfg;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_MUL,
        OP_LOAD_PCT,
        OP_DSTEP,
        OP_PCT,
        OP_STATS,
        OP_MEAN_OUT
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_VALID,
        COND_SAT,
        COND_DIV_LAST,
        COND_SKIP,
        COND_OUT_FREE
    } t_cond;

    // One control word: jump to target when cond holds, else hold or advance
    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic               stay;
        logic [PC_BITS-1:0] target;
    } t_ctrl;

    // Status fed back from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic sat;
        logic div_last;
        logic skip;
        logic out_free;
    } t_flags;

    // Microprogram table
    function automatic t_ctrl prog_word(input logic [PC_BITS-1:0] pc);
        t_ctrl w;
        unique case (pc)
            PC_IDLE:  w = '{OP_WAIT,     COND_IN_VALID, 1'b1, PC_MUL};
            PC_MUL:   w = '{OP_MUL,      COND_NEVER,    1'b0, PC_IDLE};
            PC_LDPCT: w = '{OP_LOAD_PCT, COND_SAT,      1'b0, PC_PCT};
            PC_DPCT:  w = '{OP_DSTEP,    COND_DIV_LAST, 1'b1, PC_PCT};
            PC_PCT:   w = '{OP_PCT,      COND_NEVER,    1'b0, PC_IDLE};
            PC_STATS: w = '{OP_STATS,    COND_SKIP,     1'b0, PC_OUT};
            PC_DMEAN: w = '{OP_DSTEP,    COND_DIV_LAST, 1'b1, PC_MEAN};
            PC_MEAN:  w = '{OP_MEAN_OUT, COND_NEVER,    1'b0, PC_IDLE};
            PC_OUT:   w = '{OP_NOP,      COND_OUT_FREE, 1'b1, PC_IDLE};
            default:  w = '{OP_NOP,      COND_ALWAYS,   1'b0, PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/mps_seq.sv @@
// ----------------------------------------------------------------------------
// mps_seq: microprogram sequencer
// Step counter over the program table with conditional jumps.
// ----------------------------------------------------------------------------
module mps_seq import mps_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    logic [PC_BITS-1:0] r_pc;
    logic [PC_BITS-1:0] n_pc;
    t_ctrl              w_word;
    logic               w_take;

    // Fetch the current control word
    assign w_word = prog_word(r_pc);
    assign o_ctrl = w_word;

    // Evaluate the jump condition
    always_comb begin
        unique case (w_word.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_IN_VALID: w_take = i_flags.in_valid;
            COND_SAT:      w_take = i_flags.sat;
            COND_DIV_LAST: w_take = i_flags.div_last;
            COND_SKIP:     w_take = i_flags.skip;
            COND_OUT_FREE: w_take = i_flags.out_free;
            default:       w_take = 1'b0;
        endcase
    end

    // Jump, hold or advance
    always_comb begin
        priority if (w_take) begin
            n_pc = w_word.target;
        end else if (w_word.stay) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

@@ hdl/mps_div.sv @@
// ----------------------------------------------------------------------------
// mps_div: shared restoring divider
// Produces one quotient bit per step; the remainder is preloaded so the
// same unit serves both the percent scaling and the mean update.
// ----------------------------------------------------------------------------
module mps_div import mps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_step,
    input  logic [DIV_BITS-1:0] i_rem_init,
    input  logic [PCT_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0] i_divisor,
    output logic [PCT_BITS-1:0] o_quot,
    output logic                o_last
);

    logic [DIV_BITS-1:0]  r_rem;
    logic [PCT_BITS-1:0]  r_acc;
    logic [DIV_BITS-1:0]  r_dvs;
    logic [STEP_BITS-1:0] r_cnt;
    logic [DIV_BITS:0]    w_trial;
    logic [DIV_BITS:0]    w_diff;
    logic                 w_ge;

    // Shift in the next dividend bit and try to subtract
    assign w_trial = {r_rem, r_acc[PCT_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = !w_diff[DIV_BITS];

    assign o_quot = r_acc;
    assign o_last = (r_cnt == '0);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= STEP_BITS'(PCT_BITS - 1);
        end else if (i_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder and dividend/quotient shifter
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rem_init;
            r_acc <= i_dividend;
            r_dvs <= i_divisor;
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[DIV_BITS-1:0] : w_trial[DIV_BITS-1:0];
            r_acc <= {r_acc[PCT_BITS-2:0], w_ge};
        end
    end

endmodule

@@ hdl/mps_datapath.sv @@
// ----------------------------------------------------------------------------
// mps_datapath: scaling and statistics datapath
// Input latch, scaling multiplier, limit check, min/max/mean stores and
// output register, each driven by the control word of the current step.
// ----------------------------------------------------------------------------
module mps_datapath import mps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl     i_ctrl,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    output t_flags    o_flags
);

    t_in_item              r_in;
    logic [PROD_BITS-1:0]  r_prod;
    logic                  r_sat;
    logic [PCT_BITS-1:0]   r_pct;
    logic                  r_oor;
    logic [PCT_BITS-1:0]   r_min;
    logic [PCT_BITS-1:0]   r_max;
    logic [PCT_BITS-1:0]   r_mean;
    logic                  r_neg;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic                  w_skip;
    logic                  w_out_free;
    logic                  w_div_load;
    logic [DIV_BITS-1:0]   w_rem_init;
    logic [PCT_BITS-1:0]   w_dividend;
    logic [DIV_BITS-1:0]   w_divisor;
    logic [PCT_BITS-1:0]   w_quot;
    logic                  w_last;
    logic [PCT_BITS-1:0]   w_pct;
    logic [PCT_BITS-1:0]   w_mag;
    logic [PCT_BITS-1:0]   w_mean_next;

    assign w_skip     = !r_in.stats_enable || (r_in.sample_count == '0);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_flags = '{
        in_valid: i_in_valid,
        sat:      r_sat,
        div_last: w_last,
        skip:     w_skip,
        out_free: w_out_free
    };

    // Divider operand select: percent scaling or mean step
    assign w_div_load = (i_ctrl.op == OP_LOAD_PCT) || ((i_ctrl.op == OP_STATS) && !w_skip);
    assign w_mag      = (r_pct < r_mean) ? (r_mean - r_pct) : (r_pct - r_mean);

    always_comb begin
        if (i_ctrl.op == OP_LOAD_PCT) begin
            w_rem_init = DIV_BITS'(r_prod >> PCT_BITS);
            w_dividend = r_prod[PCT_BITS-1:0];
            w_divisor  = DIV_BITS'(i_cfg.full_scale);
        end else begin
            w_rem_init = '0;
            w_dividend = w_mag;
            w_divisor  = DIV_BITS'(r_in.sample_count);
        end
    end

    mps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_div_load),
        .i_step     (i_ctrl.op == OP_DSTEP),
        .i_rem_init (w_rem_init),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_last     (w_last)
    );

    assign w_pct       = r_sat ? PCT_FULL : w_quot;
    assign w_mean_next = r_neg ? (r_mean - w_quot) : (r_mean + w_quot);

    // Latch the input beat, scale, check limits
    always_ff @(posedge i_clk) begin
        if ((i_ctrl.op == OP_WAIT) && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (i_ctrl.op == OP_MUL) begin
            r_prod <= PROD_BITS'(r_in.sample) * PROD_BITS'(PCT_FULL);
            r_sat  <= CMP_BITS'(r_in.sample) >= CMP_BITS'(i_cfg.full_scale);
        end
        if (i_ctrl.op == OP_PCT) begin
            r_pct <= w_pct;
            r_oor <= (w_pct > i_cfg.high_limit) || (w_pct < i_cfg.low_limit);
        end
        if (i_ctrl.op == OP_STATS) begin
            r_neg <= r_pct < r_mean;
        end
    end

    // Statistics stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_max  <= '0;
            r_mean <= '0;
        end else if ((i_ctrl.op == OP_STATS) && r_in.stats_enable) begin
            if (r_in.sample_count == '0) begin
                r_min  <= r_pct;
                r_max  <= r_pct;
                r_mean <= '0;
            end else begin
                if (r_pct < r_min) begin
                    r_min <= r_pct;
                end
                if (r_pct > r_max) begin
                    r_max <= r_pct;
                end
            end
        end else if (i_ctrl.op == OP_MEAN_OUT) begin
            r_mean <= w_mean_next;
        end
    end

    // Output register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_ctrl.op == OP_NOP) && (i_ctrl.cond == COND_OUT_FREE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctrl.op == OP_NOP) && (i_ctrl.cond == COND_OUT_FREE) && w_out_free) begin
            r_out <= '{
                percent:      r_pct,
                out_of_range: r_oor,
                minimum:      r_min,
                maximum:      r_max,
                average:      r_mean
            };
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/moisture_percent_running_stats.sv @@
// ----------------------------------------------------------------------------
// moisture_percent_running_stats: moisture percent with running statistics
// Scales a raw converter sample to Q7.8 percent, flags limit violations and
// keeps running minimum, maximum and incremental mean.
//
//   channel  direction  signals                          beat
//   in       sink       i_in_valid/o_in_ready/i_in_data   one sample item
//   out      source     o_out_valid/i_out_ready/o_out_data one result item
//   cfg      sink       i_cfg_valid/o_cfg_ready/i_cfg_*   one register write
//
// An item is taken only in the idle step, and the input stays closed until
// its result is loaded into the output register. On the way it makes up to
// two passes of 15 steps through the one shared restoring divider. A
// saturated sample skips the first pass; disabled statistics or a restart
// skip the second. Reset is synchronous and needs no clearing pass. The
// result waits in an output register, so the next beat is taken while a
// stalled result is pending; a new result waits only for that register.
// ----------------------------------------------------------------------------
module moisture_percent_running_stats import mps_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_ctrl  w_ctrl;
    t_flags w_flags;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (w_ctrl.op == OP_WAIT);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_scale <= {FS_BITS{1'b1}};
            r_cfg.high_limit <= PCT_FULL;
            r_cfg.low_limit  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FULL_SCALE: r_cfg.full_scale <= i_cfg_data[FS_BITS-1:0];
                CFG_HIGH_LIMIT: r_cfg.high_limit <= i_cfg_data[PCT_BITS-1:0];
                CFG_LOW_LIMIT:  r_cfg.low_limit  <= i_cfg_data[PCT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    mps_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_flags     (w_flags)
    );

    // Saturation never lets a result exceed full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.percent <= PCT_FULL))
        else $error("percent above full scale");

    // Running minimum never passes the running maximum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.minimum <= o_out_data.maximum))
        else $error("minimum above maximum");

    // One item at a time: the beat after acceptance finds the input closed
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input reopened during processing");

    // Flag agrees with the limits in force
    a_oor_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_of_range ==
            ((o_out_data.percent > r_cfg.high_limit) ||
             (o_out_data.percent < r_cfg.low_limit))))
        else $error("out of range flag mismatch");

endmodule

@@ tb/tb_moisture_percent_running_stats.sv @@
// ----------------------------------------------------------------------------
// tb_moisture_percent_running_stats: self-checking bench for moisture stats
// Drives sample beats and register writes over valid/ready channels, predicts
// every result beat (scaled Q7.8 percent, limit flag, running min/max/mean)
// with an independent model and compares each result field by field. Both
// sides stall at random; one long output hold fills the block and one pause
// drains it completely.
// ----------------------------------------------------------------------------
module tb_moisture_percent_running_stats import mps_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_GAP = 12;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in_item                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out_item                o_out_data;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // Model copy of registers and statistics
    logic [FS_BITS-1:0]  full_scale_q = 16'hFFFF;
    logic [PCT_BITS-1:0] high_limit_q = PCT_FULL;
    logic [PCT_BITS-1:0] low_limit_q = '0;
    logic [PCT_BITS-1:0] min_pct = '0;
    logic [PCT_BITS-1:0] max_pct = '0;
    logic [PCT_BITS-1:0] mean_pct = '0;

    t_out_item expected_readings[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        steady = 1'b0;
    int        hold_request = 0;

    moisture_percent_running_stats uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Scale a raw code to Q7.8 percent, saturated at full
    function automatic logic [PCT_BITS-1:0] scale_to_percent(input logic [SAMPLE_BITS-1:0] raw);
        longint unsigned q;
        if (full_scale_q == '0) return PCT_FULL;
        q = raw;
        q = (q * PCT_FULL) / full_scale_q;
        if (q > PCT_FULL) q = PCT_FULL;
        return PCT_BITS'(q);
    endfunction

    // Advance the statistics for one sample and return the reading it yields
    function automatic t_out_item advance_stats(input t_in_item it);
        t_out_item r;
        logic [PCT_BITS-1:0] pct;
        longint diff;
        longint cnt;
        longint next_mean;
        pct = scale_to_percent(it.sample);
        if (it.stats_enable) begin
            if (it.sample_count == '0) begin
                min_pct = pct;
                max_pct = pct;
                mean_pct = '0;
            end else begin
                if (pct < min_pct) min_pct = pct;
                if (pct > max_pct) max_pct = pct;
                cnt = it.sample_count;
                diff = pct;
                diff = diff - mean_pct;
                next_mean = mean_pct;
                next_mean = next_mean + diff / cnt;
                if (next_mean < 0) next_mean = 0;
                if (next_mean > PCT_FULL) next_mean = PCT_FULL;
                mean_pct = PCT_BITS'(next_mean);
            end
        end
        r.percent = pct;
        r.out_of_range = (pct > high_limit_q) || (pct < low_limit_q);
        r.minimum = min_pct;
        r.maximum = max_pct;
        r.average = mean_pct;
        return r;
    endfunction

    function automatic t_in_item reading(input int unsigned sample, input bit en,
                                         input int unsigned count);
        t_in_item it;
        it.sample = SAMPLE_BITS'(sample);
        it.stats_enable = en;
        it.sample_count = COUNT_BITS'(count);
        return it;
    endfunction

    // Pick a sample biased around the configured full scale
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned top;
        top = full_scale_q;
        case ($urandom_range(0, 3))
            0: return SAMPLE_BITS'($urandom);
            1: return SAMPLE_BITS'($urandom_range(0, top));
            2: return SAMPLE_BITS'($urandom_range(top > 2 ? top - 2 : 0,
                                                  top > 65533 ? 65535 : top + 2));
            default: return SAMPLE_BITS'($urandom_range(0, top / 4));
        endcase
    endfunction

    // Offer one sample beat after a random gap, hold it until taken
    task automatic send_reading(input t_in_item it);
        int gap;
        logic taken;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        expected_readings.push_back(advance_stats(it));
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        logic taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        case (idx)
            CFG_FULL_SCALE: full_scale_q = data;
            CFG_HIGH_LIMIT: high_limit_q = data[PCT_BITS-1:0];
            CFG_LOW_LIMIT:  low_limit_q = data[PCT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_limits(input logic [CFG_DATA_BITS-1:0] fs,
                                  input logic [CFG_DATA_BITS-1:0] hi,
                                  input logic [CFG_DATA_BITS-1:0] lo);
        write_reg(CFG_FULL_SCALE, fs);
        write_reg(CFG_HIGH_LIMIT, hi);
        write_reg(CFG_LOW_LIMIT, lo);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop both request lines and wait until every reading has come back
    task automatic quiesce();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reading(input t_out_item got);
        t_out_item want;
        if (expected_readings.size() == 0) begin
            $error("result beat with nothing pending: percent %0d", got.percent);
            mismatches++;
            return;
        end
        want = expected_readings.pop_front();
        compare_field("percent", want.percent, got.percent);
        compare_field("out_of_range", want.out_of_range, got.out_of_range);
        compare_field("minimum", want.minimum, got.minimum);
        compare_field("maximum", want.maximum, got.maximum);
        compare_field("average", want.average, got.average);
    endtask

    // Result sink: random stalls, long holds on request
    initial begin
        int stall;
        logic got;
        t_out_item beat;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                do begin
                    @(negedge i_clk);
                    got = o_out_valid;
                    beat = o_out_data;
                    @(posedge i_clk);
                end while (!got && hold_request == 0);
                if (got) check_reading(beat);
            end
        end
    end

    // Reset values; stats used before any restart; disabled and count extremes
    task automatic test_reset_defaults();
        send_reading(reading(20000, 1'b1, 3));
        send_reading(reading(0, 1'b1, 0));
        send_reading(reading(65535, 1'b1, 1));
        send_reading(reading(32768, 1'b1, 2));
        send_reading(reading(1, 1'b1, 65535));
        send_reading(reading(12345, 1'b0, 0));
        send_reading(reading(65535, 1'b1, 65535));
    endtask

    // Limit edges, exact full scale, overrange, masked high bits, spare index
    task automatic test_scaling_and_limits();
        quiesce();
        write_reg(CFG_SPARE, 16'hFFFF);
        program_limits(16'd1000, 16'h8000 | 16'd20000, 16'h8000 | 16'd5000);
        send_reading(reading(0, 1'b1, 0));
        send_reading(reading(195, 1'b1, 1));
        send_reading(reading(196, 1'b1, 2));
        send_reading(reading(781, 1'b1, 3));
        send_reading(reading(782, 1'b1, 4));
        send_reading(reading(1000, 1'b1, 5));
        send_reading(reading(1001, 1'b1, 6));
        send_reading(reading(65535, 1'b0, 9));
    endtask

    // Zero full scale, crossed limits, smallest scale, widest limits
    task automatic test_degenerate_config();
        quiesce();
        program_limits(16'd0, 16'd10000, 16'd20000);
        send_reading(reading(0, 1'b1, 0));
        send_reading(reading(40000, 1'b1, 1));
        quiesce();
        program_limits(16'd1, 16'd0, 16'h7FFF);
        send_reading(reading(0, 1'b1, 0));
        send_reading(reading(1, 1'b1, 1));
        send_reading(reading(0, 1'b1, 2));
        quiesce();
        program_limits(16'hFFFF, 16'h7FFF, 16'd0);
        send_reading(reading(65534, 1'b1, 0));
    endtask

    // Hold the sink long enough that the block stalls its input
    task automatic test_backpressure();
        quiesce();
        steady = 1'b1;
        hold_request = 400;
        send_reading(reading(pick_sample(), 1'b1, 0));
        for (int k = 1; k < 16; k++) send_reading(reading(pick_sample(), 1'b1, k));
        steady = 1'b0;
    endtask

    // Pause the source until the block has drained, then resume the run
    task automatic test_drain_pause();
        quiesce();
        for (int k = 0; k < 6; k++) send_reading(reading(pick_sample(), 1'b1, k));
        quiesce();
        for (int k = 6; k < 12; k++) send_reading(reading(pick_sample(), 1'b1, k));
    endtask

    // Restart runs with random samples, plus broken runs and noise beats
    task automatic run_sequences(input int n);
        int sent;
        int kind;
        int len;
        int unsigned base;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 7);
            if (kind < 6) begin
                len = $urandom_range(2, 12);
                base = (kind == 5) ? $urandom_range(1, 60000) : 0;
                for (int k = 0; k < len; k++) begin
                    send_reading(reading(pick_sample(), 1'b1, base + k));
                end
                sent += len;
            end else begin
                send_reading(reading(pick_sample(), kind == 6 ? $urandom_range(0, 1) : 1'b0,
                                     $urandom));
                sent++;
            end
        end
    endtask

    // Random register settings per phase; some phases run without idling
    task automatic test_random_phases();
        int unsigned fs;
        int unsigned hi;
        int unsigned lo;
        for (int ph = 0; ph < 8; ph++) begin
            quiesce();
            steady = (ph % 4 == 3);
            fs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 65535);
            if (ph == 5) fs = 0;
            hi = $urandom_range(0, 25600);
            lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25600) : $urandom_range(0, hi);
            program_limits(16'(fs), {1'($urandom), 15'(hi)}, {1'($urandom), 15'(lo)});
            run_sequences(60);
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_scaling_and_limits();
        test_degenerate_config();
        test_backpressure();
        test_drain_pause();
        test_random_phases();
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
